FILE: sv/hhlp_pkg.sv
// ----------------------------------------------------------------------------
// hhlp_pkg
// Shared types and constants for the HTTP header line parser: byte codes,
// parse phases, byte classes, error codes and the result beat layout.
// ----------------------------------------------------------------------------
package hhlp_pkg;

  localparam int unsigned LEN_W = 10;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [LEN_W-1:0] VALUE_LIMIT_RESET = 10'd256;

  // Characters that drive the grammar.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Parse phases; unused codes behave like the start phase.
  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_NAME   = 4'd1,
    PH_COLON  = 4'd2,
    PH_VALUE  = 4'd3,
    PH_CR     = 4'd4,
    PH_LF     = 4'd5,
    PH_END_CR = 4'd6,
    PH_BODY   = 4'd7,
    PH_ERROR  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    CLS_DELIM = 2'd0,
    CLS_NAME  = 2'd1,
    CLS_VALUE = 2'd2,
    CLS_BODY  = 2'd3
  } byte_class_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_CRLF_NAME = 3'd1,
    ERR_NO_SPACE  = 3'd2,
    ERR_TOO_LONG  = 3'd3,
    ERR_NO_LF     = 3'd4
  } error_code_t;

  // One result beat.
  typedef struct packed {
    error_code_t      error_code;
    logic [LEN_W-1:0] value_length;
    logic [LEN_W-1:0] name_length;
    logic             header_done;
    logic             pair_done;
    byte_class_t      byte_class;
  } result_t;

endpackage

FILE: sv/hhlp_fsm.sv
// ----------------------------------------------------------------------------
// hhlp_fsm
// Grammar state machine with name and value counters and the sticky error.
// Computes the result of the current byte combinationally and advances the
// state on each accepted beat.
// ----------------------------------------------------------------------------
module hhlp_fsm (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                data_byte,
  input  logic                      clear_parser,
  input  logic [hhlp_pkg::LEN_W-1:0] value_limit,
  output hhlp_pkg::result_t         result
);
  import hhlp_pkg::*;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] name_count, name_count_next;
  logic [LEN_W-1:0] value_count, value_count_next;
  error_code_t      latched_error, latched_error_next;

  // Starting point of this byte after an optional clear.
  phase_t           phase_cur;
  logic [LEN_W-1:0] name_cur;
  logic [LEN_W-1:0] value_cur;
  error_code_t      error_cur;
  logic             is_crlf;

  assign phase_cur = clear_parser ? PH_START : phase;
  assign name_cur  = clear_parser ? '0 : name_count;
  assign value_cur = clear_parser ? '0 : value_count;
  assign error_cur = clear_parser ? ERR_NONE : latched_error;
  assign is_crlf   = data_byte inside {CH_CR, CH_LF};

  // Next state, counters and error.
  always_comb begin
    phase_next         = phase_cur;
    name_count_next    = name_cur;
    value_count_next   = value_cur;
    latched_error_next = error_cur;
    case (phase_cur)
      PH_NAME: begin
        if (data_byte == CH_COLON) begin
          phase_next = PH_COLON;
        end else if (is_crlf) begin
          phase_next         = PH_ERROR;
          latched_error_next = ERR_CRLF_NAME;
        end else if (name_cur != LEN_MAX) begin
          name_count_next = name_cur + 1'b1;
        end
      end
      PH_COLON: begin
        if (data_byte == CH_SPACE) begin
          value_count_next = '0;
          phase_next       = PH_VALUE;
        end else begin
          phase_next         = PH_ERROR;
          latched_error_next = ERR_NO_SPACE;
        end
      end
      PH_VALUE: begin
        if (data_byte == CH_CR) begin
          phase_next = PH_CR;
        end else if (value_cur >= value_limit) begin
          phase_next         = PH_ERROR;
          latched_error_next = ERR_TOO_LONG;
        end else begin
          value_count_next = value_cur + 1'b1;
        end
      end
      PH_CR: begin
        if (data_byte == CH_LF) begin
          phase_next = PH_LF;
        end else begin
          phase_next         = PH_ERROR;
          latched_error_next = ERR_NO_LF;
        end
      end
      PH_LF: begin
        if (data_byte == CH_CR) begin
          phase_next = PH_END_CR;
        end else if (data_byte == CH_LF) begin
          phase_next         = PH_ERROR;
          latched_error_next = ERR_CRLF_NAME;
        end else begin
          phase_next       = PH_NAME;
          name_count_next  = LEN_W'(1);
          value_count_next = '0;
        end
      end
      PH_END_CR: begin
        if (data_byte == CH_LF) begin
          phase_next = PH_BODY;
        end else begin
          phase_next         = PH_ERROR;
          latched_error_next = ERR_NO_LF;
        end
      end
      PH_BODY, PH_ERROR: begin
        phase_next = phase_cur;
      end
      default: begin
        // Start phase: skip leading CR/LF, anything else opens a name.
        if (is_crlf) begin
          phase_next = PH_START;
        end else begin
          phase_next       = PH_NAME;
          name_count_next  = LEN_W'(1);
          value_count_next = '0;
        end
      end
    endcase
  end

  // Result of this byte.
  always_comb begin
    result              = '0;
    result.error_code   = latched_error_next;
    case (phase_cur)
      PH_NAME: begin
        if (data_byte != CH_COLON && !is_crlf) begin
          result.byte_class = CLS_NAME;
        end
      end
      PH_VALUE: begin
        if (data_byte != CH_CR && value_cur < value_limit) begin
          result.byte_class = CLS_VALUE;
        end
      end
      PH_CR: begin
        if (data_byte == CH_LF) begin
          result.pair_done    = 1'b1;
          result.name_length  = name_cur;
          result.value_length = value_cur;
        end
      end
      PH_LF: begin
        if (!is_crlf) begin
          result.byte_class = CLS_NAME;
        end
      end
      PH_END_CR: begin
        result.header_done = (data_byte == CH_LF);
      end
      PH_BODY: begin
        result.byte_class = CLS_BODY;
      end
      PH_COLON, PH_ERROR: begin
        result.byte_class = CLS_DELIM;
      end
      default: begin
        if (!is_crlf) begin
          result.byte_class = CLS_NAME;
        end
      end
    endcase
  end

  // State registers, advanced once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      name_count    <= '0;
      value_count   <= '0;
      latched_error <= ERR_NONE;
    end else if (accept) begin
      phase         <= phase_next;
      name_count    <= name_count_next;
      value_count   <= value_count_next;
      latched_error <= latched_error_next;
    end
  end

endmodule

FILE: sv/hhlp_out_buf.sv
// ----------------------------------------------------------------------------
// hhlp_out_buf
// Output register with a skid entry. Takes a result beat whenever the skid
// entry is empty, so the input side keeps moving while one result waits.
// ----------------------------------------------------------------------------
module hhlp_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hhlp_pkg::result_t   in_result,
  output logic                out_valid,
  input  logic                out_ready,
  output hhlp_pkg::result_t   out_result
);
  import hhlp_pkg::*;

  logic    skid_valid;
  result_t skid_result;
  logic    push;
  logic    out_load;

  assign in_ready = !skid_valid;
  assign push     = in_valid && !skid_valid;
  assign out_load = !out_valid || out_ready;

  // Control: output and skid occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves with the control above.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        out_result <= skid_result;
      end else if (push) begin
        out_result <= in_result;
      end
    end else if (push) begin
      skid_result <= in_result;
    end
  end

endmodule

FILE: sv/http_header_line_parser_core.sv
// ----------------------------------------------------------------------------
// http_header_line_parser_core
// Each result beat is registered, through the skid entry if the output stalls,
// once its header byte is taken. Throughput: one byte per cycle while the skid
// entry is empty; a skid entry keeps input flowing for one stalled output beat.
// Reset (rst, synchronous): parser returns to the start phase with counts and
// error cleared, output buffer empties, value_limit returns to 256.
// ----------------------------------------------------------------------------
module http_header_line_parser_core (
  input  logic        clk,
  input  logic        rst,
  // Input beats.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] clear_parser
  // Result beats.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [9:0] name_length, [19:10] value_length,
                                 // [22:20] error_code, [23] zero
  output logic [3:0]  m_tuser,   // [1:0] byte_class, [2] pair_done, [3] header_done
  // Configuration: value_limit.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);
  import hhlp_pkg::*;

  logic [LEN_W-1:0] value_limit;
  result_t          fsm_result;
  result_t          out_result;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  // Value length limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      value_limit <= VALUE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      value_limit <= cfg_data;
    end
  end

  hhlp_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_tdata),
    .clear_parser (s_tuser[0]),
    .value_limit  (value_limit),
    .result       (fsm_result)
  );

  hhlp_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_result  (fsm_result),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  // Pack the result beat onto the stream fields.
  assign m_tdata = {1'b0, out_result.error_code, out_result.value_length,
                    out_result.name_length};
  assign m_tuser = {out_result.header_done, out_result.pair_done,
                    out_result.byte_class};

endmodule
